// ----- rtl/hrd_pkg.sv -----
// shared types and constants for the receive deframer
`timescale 1ns / 1ps
`default_nettype none

package hrd_pkg;

    // field widths
    localparam int LEN_W  = 24;
    localparam int OFF_W  = 25;
    localparam int BYTE_W = 8;

    // default frame payload size
    localparam int unsigned HRD_PAYLOAD_BYTES = 62;

    // reset value of the reported buffer capacity
    localparam logic [LEN_W-1:0] CAP_RESET = 24'd20;

    // header framing
    localparam logic [BYTE_W-1:0] MARKER     = 8'hA5;
    localparam logic [2:0]        HEADER_LEN = 3'd5;
    localparam logic [2:0]        HEADER_SAT = 3'd6;
    localparam logic [2:0]        LEN_LAST   = 3'd3;

    // input commands
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_EOF  = 2'd1;
    localparam logic [1:0] CMD_FAIL = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_FAILED  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_REQUEST = 2'd1;
    localparam logic [1:0] ST_PROTOCOL   = 2'd2;
    localparam logic [1:0] ST_READ_FAIL  = 2'd3;

    // reply byte positions
    localparam logic [2:0] RPL_MARK0 = 3'd0;
    localparam logic [2:0] RPL_CAP_H = 3'd1;
    localparam logic [2:0] RPL_CAP_M = 3'd2;
    localparam logic [2:0] RPL_CAP_L = 3'd3;
    localparam logic [2:0] RPL_MARK1 = 3'd4;

    // event handed from the decoder to the output stage;
    // for a reply burst total_length carries the buffer capacity
    typedef struct packed {
        logic               valid;
        logic               reply;
        logic [1:0]         kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   total_length;
        logic [1:0]         status_code;
    } hrd_event_t;

endpackage

`default_nettype wire

// ----- rtl/hlp_receive_deframer.sv -----
// Receive deframer: one item accepted per cycle when the result register is free.
// Latency: the result of an accepted item is registered and appears on the output in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; a good request header yields a 5-item reply,
// during which the input waits until the last reply item is taken.
// Reset (rst_n low, asynchronous): waits for a request header, capacity 20.
`timescale 1ns / 1ps
`default_nettype none

module hlp_receive_deframer #(
    parameter int unsigned PAYLOAD_BYTES = hrd_pkg::HRD_PAYLOAD_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata,   // buffer_capacity
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // in_byte
    input  wire logic [1:0]  s_tuser,     // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,     // data_byte, byte_offset, total_length, status_code
    output logic [1:0]       m_tuser,     // kind
    output logic             m_tlast      // reply_last
);
    import hrd_pkg::*;

    localparam int FL_W = $clog2((2**LEN_W - 1) / PAYLOAD_BYTES + 2);

    logic [LEN_W-1:0] announced_len;
    logic [FL_W-1:0]  len_quot;
    hrd_event_t       ev;
    logic             free;

    assign s_tready = free;

    // frame count from the announced length
    hrd_len_div #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_len_div (
        .clk  (clk),
        .len  (announced_len),
        .quot (len_quot)
    );

    // decoder and transfer state
    hrd_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .in_ready      (free),
        .in_cmd        (s_tuser),
        .in_byte       (s_tdata),
        .len_quot      (len_quot),
        .announced_len (announced_len),
        .ev            (ev)
    );

    // result register and reply sequencing
    hrd_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/hrd_len_div.sv -----
// registered quotient of the announced length by the frame payload size
`timescale 1ns / 1ps
`default_nettype none

module hrd_len_div #(
    parameter int unsigned PAYLOAD_BYTES = hrd_pkg::HRD_PAYLOAD_BYTES,
    localparam int FL_W = $clog2((2**hrd_pkg::LEN_W - 1) / PAYLOAD_BYTES + 2)
) (
    input  wire logic                      clk,
    input  wire logic [hrd_pkg::LEN_W-1:0] len,
    output logic      [FL_W-1:0]           quot
);
    import hrd_pkg::*;

    // rounded-up reciprocal: error term stays below 2**(LEN_W-SHIFT)
    localparam int SHIFT = LEN_W + $clog2(PAYLOAD_BYTES);
    localparam int RECIP_W = LEN_W + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
    localparam int PROD_W = LEN_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [FL_W-1:0]   quot_reg;
    logic [FL_W-1:0]   quot_next;

    // multiply by reciprocal and take the high part
    assign prod = {{RECIP_W{1'b0}}, len} * {{LEN_W{1'b0}}, RECIP_W'(RECIP)};
    assign quot_next = prod[SHIFT +: FL_W];

    // quotient register, follows the length in the next cycle
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/hrd_core.sv -----
// header and frame decoder with transfer state, one item per cycle while in_ready is high
`timescale 1ns / 1ps
`default_nettype none

module hrd_core #(
    parameter int unsigned PAYLOAD_BYTES = hrd_pkg::HRD_PAYLOAD_BYTES,
    localparam int FL_W = $clog2((2**hrd_pkg::LEN_W - 1) / PAYLOAD_BYTES + 2)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [hrd_pkg::LEN_W-1:0]    cfg_wdata,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [1:0]                   in_cmd,
    input  wire logic [hrd_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic [FL_W-1:0]              len_quot,
    output logic      [hrd_pkg::LEN_W-1:0]    announced_len,
    output hrd_pkg::hrd_event_t               ev
);
    import hrd_pkg::*;

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 2);
    localparam int REM_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_FRAMES = 1'b1;

    logic               phase_reg, phase_next;
    logic [2:0]         hcount_reg, hcount_next;
    logic               hgood_reg, hgood_next;
    logic [LEN_W-1:0]   alen_reg, alen_next;
    logic [FL_W-1:0]    fleft_reg, fleft_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [7:0]         fnum_reg, fnum_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               fgood_reg, fgood_next;
    logic [LEN_W-1:0]   cap_reg;
    logic               fire;
    logic               go_header;
    logic [FL_W-1:0]    fleft_dec;
    hrd_event_t         ev_c;

    assign fire = in_valid && in_ready;
    assign fleft_dec = (fleft_reg != '0) ? fleft_reg - 1'b1 : fleft_reg;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // next-state and event decode
    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        hgood_next  = hgood_reg;
        alen_next   = alen_reg;
        fleft_next  = fleft_reg;
        offset_next = offset_reg;
        rem_next    = rem_reg;
        fnum_next   = fnum_reg;
        pos_next    = pos_reg;
        fgood_next  = fgood_reg;
        go_header   = 1'b0;
        ev_c        = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (in_cmd) inside
                        CMD_BYTE:
                        begin
                            // collect header bytes, length big-endian
                            if (hcount_reg == '0)
                            begin
                                alen_next  = '0;
                                hgood_next = (in_byte == MARKER);
                            end
                            else if (hcount_reg <= LEN_LAST)
                            begin
                                alen_next = {alen_reg[LEN_W-BYTE_W-1:0], in_byte};
                            end
                            else if (hcount_reg == HEADER_LEN - 3'd1)
                            begin
                                if (in_byte != MARKER)
                                begin
                                    hgood_next = 1'b0;
                                end
                            end
                            else
                            begin
                                hgood_next = 1'b0;
                            end
                            if (hcount_reg < HEADER_SAT)
                            begin
                                hcount_next = hcount_reg + 3'd1;
                            end
                        end
                        CMD_EOF, CMD_FAIL:
                        begin
                            if (in_cmd == CMD_EOF && hcount_reg == HEADER_LEN && hgood_reg)
                            begin
                                // good request: send reply and start frames
                                ev_c.valid        = 1'b1;
                                ev_c.reply        = 1'b1;
                                ev_c.kind         = KIND_REPLY;
                                ev_c.total_length = cap_reg;
                                phase_next  = PH_FRAMES;
                                hcount_next = '0;
                                hgood_next  = 1'b1;
                                fleft_next  = len_quot + 1'b1;
                                offset_next = '0;
                                rem_next    = '0;
                                fnum_next   = '0;
                                pos_next    = '0;
                                fgood_next  = 1'b1;
                            end
                            else
                            begin
                                ev_c.valid       = 1'b1;
                                ev_c.kind        = KIND_FAILED;
                                ev_c.status_code = ST_NO_REQUEST;
                                go_header        = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_FRAMES:
                begin
                    unique case (in_cmd) inside
                        CMD_FAIL:
                        begin
                            ev_c.valid       = 1'b1;
                            ev_c.kind        = KIND_FAILED;
                            ev_c.status_code = ST_READ_FAIL;
                            go_header        = 1'b1;
                        end
                        CMD_BYTE:
                        begin
                            if (pos_reg == '0)
                            begin
                                // frame number check
                                if (in_byte != fnum_reg)
                                begin
                                    fgood_next = 1'b0;
                                end
                            end
                            else if (pos_reg <= POS_W'(PAYLOAD_BYTES))
                            begin
                                if (fgood_reg)
                                begin
                                    ev_c.valid       = 1'b1;
                                    ev_c.kind        = KIND_PAYLOAD;
                                    ev_c.data_byte   = in_byte;
                                    ev_c.byte_offset = offset_reg;
                                    offset_next      = offset_reg + 1'b1;
                                    // track offset / payload size and its remainder
                                    if (offset_reg == '1)
                                    begin
                                        rem_next  = '0;
                                        fnum_next = '0;
                                    end
                                    else if (rem_reg == REM_W'(PAYLOAD_BYTES - 1))
                                    begin
                                        rem_next  = '0;
                                        fnum_next = fnum_reg + 8'd1;
                                    end
                                    else
                                    begin
                                        rem_next = rem_reg + 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                fgood_next = 1'b0;
                            end
                            if (pos_reg <= POS_W'(PAYLOAD_BYTES))
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        CMD_EOF:
                        begin
                            if (pos_reg == '0 || !fgood_reg)
                            begin
                                ev_c.valid       = 1'b1;
                                ev_c.kind        = KIND_FAILED;
                                ev_c.status_code = ST_PROTOCOL;
                                go_header        = 1'b1;
                            end
                            else
                            begin
                                pos_next   = '0;
                                fgood_next = 1'b1;
                                fleft_next = fleft_dec;
                                if (fleft_dec == '0)
                                begin
                                    ev_c.valid        = 1'b1;
                                    ev_c.kind         = KIND_DONE;
                                    ev_c.total_length = alen_reg;
                                    go_header         = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        // back to waiting for a request header
        if (go_header)
        begin
            phase_next  = PH_HEADER;
            hcount_next = '0;
            hgood_next  = 1'b1;
            fleft_next  = '0;
            pos_next    = '0;
            fgood_next  = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            hgood_reg  <= 1'b1;
            alen_reg   <= '0;
            fleft_reg  <= '0;
            offset_reg <= '0;
            rem_reg    <= '0;
            fnum_reg   <= '0;
            pos_reg    <= '0;
            fgood_reg  <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            hgood_reg  <= hgood_next;
            alen_reg   <= alen_next;
            fleft_reg  <= fleft_next;
            offset_reg <= offset_next;
            rem_reg    <= rem_next;
            fnum_reg   <= fnum_next;
            pos_reg    <= pos_next;
            fgood_reg  <= fgood_next;
        end
    end

    assign announced_len = alen_reg;
    assign ev            = ev_c;

    // frames phase always has at least one frame outstanding
    a_frames_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FRAMES |-> fleft_reg != '0)
        else $error("frames phase with no frame left");

    // header counter saturates
    a_hcount_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hcount_reg <= HEADER_SAT)
        else $error("header counter past saturation");

    // an event only comes from an accepted item
    a_event_fire: assert property (@(posedge clk) disable iff (!rst_n)
        ev_c.valid |-> fire)
        else $error("event without accepted item");

endmodule

`default_nettype wire

// ----- rtl/hrd_out.sv -----
// result register with reply burst sequencing
`timescale 1ns / 1ps
`default_nettype none

module hrd_out (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hrd_pkg::hrd_event_t  ev,
    output logic                      free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,  // data_byte, byte_offset, total_length, status_code
    output logic [1:0]                m_tuser,  // kind
    output logic                      m_tlast   // reply_last
);
    import hrd_pkg::*;

    logic       busy_reg;
    logic [2:0] idx_reg;
    hrd_event_t ev_reg;
    logic       take;
    logic       last_beat;
    logic       load;
    logic [BYTE_W-1:0] rdata;

    assign take      = busy_reg && m_tready;
    assign last_beat = !ev_reg.reply || (idx_reg == RPL_MARK1);
    assign free      = !busy_reg || (take && last_beat);
    assign load      = ev.valid;

    // burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (last_beat)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= ev;
        end
    end

    // reply byte select
    always_comb
    begin
        unique case (idx_reg)
            RPL_MARK0: rdata = MARKER;
            RPL_CAP_H: rdata = ev_reg.total_length[23:16];
            RPL_CAP_M: rdata = ev_reg.total_length[15:8];
            RPL_CAP_L: rdata = ev_reg.total_length[7:0];
            RPL_MARK1: rdata = MARKER;
            default:   rdata = MARKER;
        endcase
    end

    // output fields
    always_comb
    begin
        m_tvalid = busy_reg;
        m_tuser  = ev_reg.kind;
        if (ev_reg.reply)
        begin
            m_tdata = {5'd0, ST_OK, {LEN_W{1'b0}}, {OFF_W{1'b0}}, rdata};
            m_tlast = (idx_reg == RPL_MARK1);
        end
        else
        begin
            m_tdata = {5'd0, ev_reg.status_code, ev_reg.total_length,
                       ev_reg.byte_offset, ev_reg.data_byte};
            m_tlast = 1'b0;
        end
    end

    // a new event never overwrites an unfinished result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || (take && last_beat)))
        else $error("result overwritten");

    // reply index stays inside the burst
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ev_reg.reply) |-> idx_reg <= RPL_MARK1)
        else $error("reply index out of range");

    // a reply burst keeps going until its last byte
    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_beat) |=> (busy_reg && idx_reg == $past(idx_reg) + 3'd1))
        else $error("reply burst broken");

endmodule

`default_nettype wire
